[hdl/mkst_pkg.sv]
// Package with the item, result and table entry types of the MAC sighting table.
package mkst_pkg;

    localparam logic ACT_OBSERVE = 1'b0;
    localparam logic ACT_READ    = 1'b1;

    localparam logic [31:0] HITS_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        action;
        logic [47:0] source_mac;
        logic [11:0] outer_vlan;
        logic        double_flag;
        logic [11:0] inner_vlan;
        logic [31:0] now_ms;
        logic [5:0]  recency_pos;
    } t_item;

    typedef struct packed {
        logic        new_entry;
        logic        dropped;
        logic        read_ok;
        logic [47:0] entry_mac;
        logic [11:0] entry_outer;
        logic        entry_double;
        logic [11:0] entry_inner;
        logic [31:0] entry_hits;
        logic [31:0] entry_seen_ms;
        logic [6:0]  fill_level;
    } t_result;

    typedef struct packed {
        logic [47:0] mac;
        logic [11:0] outer_vlan;
        logic        double_flag;
        logic [11:0] inner_vlan;
        logic [31:0] hits;
        logic [31:0] seen_ms;
    } t_entry;

endpackage

[hdl/mkst_if.sv]
// Valid/ready channel interfaces for the input items and the result items.
interface mkst_item_if
    import mkst_pkg::*;
();
    logic  valid;
    logic  ready;
    t_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mkst_result_if
    import mkst_pkg::*;
();
    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/mkst_entry_store.sv]
// Table entry memory with one write port and one registered read port.
module mkst_entry_store
    import mkst_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/mac_keyed_sighting_table_unit.sv]
// Top level of the MAC sighting table: sequencer, entry search and result register.
// An observe item does one memory read and one key compare per stored entry up to the
// first match, pipelined through the store's read port.
// A read item passes through S_RADDR, S_RDATA and S_DONE; a read beyond the fill level goes straight to S_DONE.
// One item is in work at a time; a new item is taken while the last result waits.
// Synchronous active-low reset empties the table; the entry memory is not cleared.
module mac_keyed_sighting_table_unit
    import mkst_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mkst_item_if.sink     i_item,
    mkst_result_if.source o_result
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int PW = (CW > 6) ? CW : 6;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_RADDR = 3'd2;
    localparam logic [2:0] S_RDATA = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_pend, n_pend;
    logic [CW-1:0] r_count, n_count;
    logic          r_out_valid, n_out_valid;
    t_item         r_key;
    t_result       r_res, n_res;
    t_result       r_out, n_out;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_entry        mem_rdata;
    logic          key_hit;
    logic          accept;

    mkst_entry_store #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign accept  = i_item.valid && i_item.ready;
    assign key_hit = r_pend && (mem_rdata.mac == r_key.source_mac);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_count     = r_count;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_result.ready;
        mem_we      = 1'b0;
        mem_waddr   = AW'(r_idx);
        mem_wdata   = mem_rdata;
        mem_raddr   = AW'(r_idx);

        case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_res = '0;
                    if (i_item.data.action == ACT_OBSERVE) begin
                        n_idx   = '0;
                        n_pend  = 1'b0;
                        n_state = S_SCAN;
                    end else if (PW'(i_item.data.recency_pos) < PW'(r_count)) begin
                        n_idx   = CW'(PW'(r_count) - PW'(1) - PW'(i_item.data.recency_pos));
                        n_state = S_RADDR;
                    end else begin
                        n_res.fill_level = 7'(r_count);
                        n_state          = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (key_hit) begin
                    mem_we                = 1'b1;
                    mem_waddr             = AW'(r_idx - 1'b1);
                    mem_wdata.mac         = mem_rdata.mac;
                    mem_wdata.outer_vlan  = r_key.outer_vlan;
                    mem_wdata.double_flag = r_key.double_flag;
                    mem_wdata.inner_vlan  = r_key.inner_vlan;
                    mem_wdata.hits        = (mem_rdata.hits == HITS_MAX) ?
                                            HITS_MAX : mem_rdata.hits + 32'd1;
                    mem_wdata.seen_ms     = r_key.now_ms;
                    n_res.fill_level      = 7'(r_count);
                    n_state               = S_DONE;
                end else if (r_idx == r_count) begin
                    if (r_count < CW'(MAX_ENTRIES)) begin
                        mem_we                = 1'b1;
                        mem_waddr             = AW'(r_count);
                        mem_wdata.mac         = r_key.source_mac;
                        mem_wdata.outer_vlan  = r_key.outer_vlan;
                        mem_wdata.double_flag = r_key.double_flag;
                        mem_wdata.inner_vlan  = r_key.inner_vlan;
                        mem_wdata.hits        = 32'd1;
                        mem_wdata.seen_ms     = r_key.now_ms;
                        n_count               = r_count + 1'b1;
                        n_res.new_entry       = 1'b1;
                        n_res.fill_level      = 7'(r_count + 1'b1);
                    end else begin
                        n_res.dropped    = 1'b1;
                        n_res.fill_level = 7'(r_count);
                    end
                    n_state = S_DONE;
                end else begin
                    n_idx  = r_idx + 1'b1;
                    n_pend = 1'b1;
                end
            end
            S_RADDR: begin
                n_state = S_RDATA;
            end
            S_RDATA: begin
                n_res.read_ok       = 1'b1;
                n_res.entry_mac     = mem_rdata.mac;
                n_res.entry_outer   = mem_rdata.outer_vlan;
                n_res.entry_double  = mem_rdata.double_flag;
                n_res.entry_inner   = mem_rdata.inner_vlan;
                n_res.entry_hits    = mem_rdata.hits;
                n_res.entry_seen_ms = mem_rdata.seen_ms;
                n_res.fill_level    = 7'(r_count);
                n_state             = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key <= i_item.data;
        end
        r_res <= n_res;
        r_out <= n_out;
    end

    assign i_item.ready   = (r_state == S_IDLE);
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

endmodule
